[src/bit_width_packer_defines.svh]
// assertion macros for the bit width packer
`ifndef BIT_WIDTH_PACKER_DEFINES_SVH
`define BIT_WIDTH_PACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define BWP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define BWP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BWP_ASSERT(label, clk, rst, prop, msg)
`define BWP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[src/bwp_pkg.sv]
// shared types and constants of the bit width packer
`default_nettype none

package bwp_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_VALUE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE      = 4'd1;

  localparam logic [3:0] BPV_RESET = 4'd8;

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [3:0] bits_per_value;
    logic       sign_mode;
  } cfg_t;

  // one to two output bytes made by one input item
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       has_two;
    logic       last;
  } job_t;

endpackage

`default_nettype wire

[src/bwp_front.sv]
// front end: bit accumulator that turns each item that completes a byte, or is marked is_last, into a byte job
`default_nettype none
`include "bit_width_packer_defines.svh"

module bwp_front
  import bwp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output logic          job_valid,
  output job_t          job
);

  logic [6:0]  pend_bits;
  logic [2:0]  pend_cnt;
  logic [6:0]  pend_bits_next;
  logic [2:0]  pend_cnt_next;

  logic [3:0]  w;
  logic [7:0]  mask;
  logic [7:0]  bits;
  logic [14:0] acc;
  logic [3:0]  total;
  logic        full_byte;
  logic        tail_byte;

  always_comb begin
    if (cfg.sign_mode || cfg.bits_per_value == 4'd0) begin
      w = 4'd1;
    end else if (cfg.bits_per_value > 4'd8) begin
      w = 4'd8;
    end else begin
      w = cfg.bits_per_value;
    end
  end

  assign mask = 8'((9'h001 << w) - 9'h001);

  // sign bit: positive as a signed byte
  assign bits = cfg.sign_mode ? {7'h00, (item.value != 8'h00) && !item.value[7]}
                              : (item.value & mask);

  assign acc   = {8'h00, pend_bits} | ({7'h00, bits} << pend_cnt);
  assign total = {1'b0, pend_cnt} + w;

  assign full_byte = total[3];
  assign tail_byte = item.is_last && (total[2:0] != 3'd0);

  always_comb begin
    job.byte0   = acc[7:0];
    job.byte1   = {1'b0, acc[14:8]};
    job.has_two = full_byte && tail_byte;
    job.last    = item.is_last;
  end

  assign job_valid = accept && (full_byte || item.is_last);

  always_comb begin
    if (item.is_last) begin
      pend_bits_next = 7'h00;
      pend_cnt_next  = 3'd0;
    end else begin
      pend_bits_next = full_byte ? acc[14:8] : acc[6:0];
      pend_cnt_next  = total[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= 7'h00;
      pend_cnt  <= 3'd0;
    end else if (accept) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  `BWP_ASSERT(a_last_clears, clk, rst, accept && item.is_last |=> pend_cnt == 3'd0, "last item left bits pending")
  `BWP_ASSERT(a_last_makes_job, clk, rst, accept && item.is_last |-> job_valid, "last item made no byte")

endmodule

`default_nettype wire

[src/bwp_queue.sv]
// short job queue between front and back
`default_nettype none
`include "bit_width_packer_defines.svh"

module bwp_queue
  import bwp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_job,
  input  wire logic rd,
  output job_t      rd_job,
  output logic      q_full,
  output logic      q_nonempty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full     = (count == QCNT_W'(QDEPTH));
  assign q_nonempty = (count != '0);
  assign rd_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `BWP_ASSERT(a_no_overflow, clk, rst, !(wr && q_full), "job written into full queue")
  `BWP_ASSERT(a_no_underflow, clk, rst, !(rd && !q_nonempty), "job read from empty queue")

endmodule

`default_nettype wire

[src/bwp_back.sv]
// back end: output register that hands out the bytes of each job
`default_nettype none
`include "bit_width_packer_defines.svh"

module bwp_back
  import bwp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t q_job,
  input  wire logic q_nonempty,
  output logic      q_rd,
  input  wire logic pop,
  output logic      empty,
  output out_item_t result
);

  logic held;
  logic idx;
  job_t cur;
  logic advance;
  logic done;

  assign empty   = !held;
  assign advance = pop && held;
  assign done    = advance && (!cur.has_two || idx);
  assign q_rd    = (!held || done) && q_nonempty;

  always_comb begin
    result.packed_byte = idx ? cur.byte1 : cur.byte0;
    result.last_byte   = cur.last && (idx || !cur.has_two);
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 1'b0;
    end else if (q_rd) begin
      held <= 1'b1;
      idx  <= 1'b0;
    end else if (done) begin
      held <= 1'b0;
      idx  <= 1'b0;
    end else if (advance) begin
      idx <= 1'b1;
    end
  end

  `BWP_ASSERT(a_second_needs_two, clk, rst, idx |-> held && cur.has_two, "second byte of one-byte job")

endmodule

`default_nettype wire

[src/bit_width_packer.sv]
// top level of the bit width packer
`default_nettype none
`include "bit_width_packer_defines.svh"

// bit width packer: takes one byte value per item and packs the low bits_per_value
// bits of each (or, in sign mode, one bit that is set when the value is positive as
// a signed byte) into bytes, least significant bit first. up to 7 bits wait between
// items; the item marked is_last flushes them as one zero-padded byte and the byte
// so made carries last_byte. an item gives zero, one or two bytes. an input item is
// taken every cycle while full is low: the combinational front accumulator writes
// a byte job into a four-entry queue. the back stage hands out one byte per pop,
// so the sustained rate is one item per cycle while items give at most one byte
// on average; an item that gives two bytes (only a last item can) takes two pops.
// results leave an output register; a waiting byte stops new items only once the
// queue is full. configuration is always ready and must be written while idle;
// the new width applies from the next item, and waiting bits stay in place.

module bit_width_packer
  import bwp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item side
  input  wire logic                  push,
  output logic                       full,
  input  wire in_item_t              item,
  // result side
  output logic                       empty,
  input  wire logic                  pop,
  output out_item_t                  result,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic accept;
  logic job_valid;
  job_t job;
  job_t q_job;
  logic q_full;
  logic q_nonempty;
  logic q_rd;

  // configuration registers, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_per_value <= BPV_RESET;
      cfg.sign_mode      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BITS_PER_VALUE: cfg.bits_per_value <= cfg_data;
        REG_SIGN_MODE:      cfg.sign_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // an item is taken whenever the job queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  bwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job)
  );

  bwp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (job_valid),
    .wr_job     (job),
    .rd         (q_rd),
    .rd_job     (q_job),
    .q_full     (q_full),
    .q_nonempty (q_nonempty)
  );

  bwp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_job      (q_job),
    .q_nonempty (q_nonempty),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  `BWP_ASSERT(a_full_blocks, clk, rst, full |-> !accept, "item taken while full")

endmodule

`default_nettype wire

[tb/bit_width_packer_test.sv]
// self-checking testbench for the bit width packer with its own packing predictor
`timescale 1ns / 100ps

module bit_width_packer_test
  import bwp_pkg::*;
();

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  // block ports, inputs known from time zero
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              item      = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_item_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit_width_packer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // items still to be offered, filled by the sequence below
  in_item_t  items_q [$];
  // bytes the packer owes us, oldest first
  out_item_t expected_bytes [$];

  // predictor copy of the registers and of the bits waiting between items
  logic [3:0] cfg_bpv   = BPV_RESET;
  logic       cfg_sign  = 1'b0;
  logic [6:0] pend_bits  = '0;
  logic [2:0] pend_count = '0;

  int  error_count    = 0;
  int  items_total    = 0;   // items queued so far
  int  items_accepted = 0;   // items taken by the block
  bit  no_idle        = 1'b0; // set for the closing stretch of the run

  // per-process counters
  int send_gap     = 0;
  int pop_gap      = 0;
  int hold_left    = 0;
  int long_holds   = 0;
  int stall_cycles = 0;

  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_HOLD    = 80;
  localparam int SETTLE_TICKS = 12;

  task automatic report_mismatch(string what, logic [8:0] got_v, logic [8:0] want_v);
    $display("mismatch %s: got %h, expected %h (item %0d)", what, got_v, want_v,
             items_accepted);
    error_count++;
  endtask

  // appends the bytes that one accepted item completes
  function automatic void pack_item(in_item_t it);
    logic [3:0]  width;
    logic [7:0]  group;
    logic [15:0] acc;
    logic [3:0]  total;
    out_item_t   one;
    // sign mode always takes one bit; out-of-range widths are clamped to 1..8
    if (cfg_sign || cfg_bpv == 4'd0) begin
      width = 4'd1;
    end else if (cfg_bpv > 4'd8) begin
      width = 4'd8;
    end else begin
      width = cfg_bpv;
    end
    // sign bit: set only for 1..127 as a signed byte
    if (cfg_sign) begin
      group = {7'd0, (it.value != 8'd0 && !it.value[7])};
    end else begin
      group = it.value & (8'hFF >> (4'd8 - width));
    end
    // new bits go right above the waiting ones
    acc   = {9'd0, pend_bits} | ({8'd0, group} << pend_count);
    total = {1'b0, pend_count} + width;
    if (total >= 4'd8) begin
      one.packed_byte = acc[7:0];
      acc   = acc >> 8;
      total = total - 4'd8;
      // a last item ending on a byte boundary marks this byte, no pad byte follows
      one.last_byte = it.is_last && total == 4'd0;
      expected_bytes.push_back(one);
    end
    if (it.is_last && total != 4'd0) begin
      // zero-padded flush of the remainder
      one.packed_byte = acc[7:0];
      one.last_byte   = 1'b1;
      expected_bytes.push_back(one);
    end
    if (it.is_last) begin
      pend_bits  = '0;
      pend_count = '0;
    end else begin
      pend_bits  = acc[6:0];
      pend_count = total[2:0];
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("byte with nothing pending", got, 9'd0);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.packed_byte !== want.packed_byte)
      report_mismatch("packed_byte", {1'b0, got.packed_byte}, {1'b0, want.packed_byte});
    if (got.last_byte !== want.last_byte)
      report_mismatch("last_byte", {8'd0, got.last_byte}, {8'd0, want.last_byte});
  endtask

  // item driver: holds an item while full, otherwise loads the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        // item taken at this edge
        pack_item(item);
        items_accepted++;
      end
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (items_q.size() != 0) begin
        push <= 1'b1;
        item <= items_q.pop_front();
        if (!no_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor: checks every popped byte and throttles pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      // twice in the run, stop popping while the sender still has plenty to offer,
      // so the internal queue fills and full has to come up
      if (hold_left == 0 && long_holds < 2 && items_q.size() > 20 &&
          items_accepted >= (long_holds + 1) * 400) begin
        hold_left = LONG_HOLD;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) pop_gap = $urandom_range(1, 3);
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL bit_width_packer");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    // register written at this edge
    if (idx == REG_BITS_PER_VALUE) begin
      cfg_bpv = data;
    end else if (idx == REG_SIGN_MODE) begin
      cfg_sign = data[0];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic put(logic [7:0] value, logic last);
    in_item_t it;
    it.value   = value;
    it.is_last = last;
    items_q.push_back(it);
    items_total++;
  endtask

  // random stream of count items; close puts is_last on the final one
  task automatic add_items(int count, bit close);
    logic [7:0] v;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 15))
        0: v = 8'h00;
        1: v = 8'h7F;
        2: v = 8'h80;
        3: v = 8'hFF;
        4: v = 8'h01;
        default: v = 8'($urandom_range(0, 255));
      endcase
      put(v, close && k == count - 1);
    end
  endtask

  // block idle: nothing queued or offered, nothing owed, then let an item that
  // made no byte finish its way through the pipe
  task automatic settle();
    do @(negedge clk); while (items_q.size() != 0 || push || expected_bytes.size() != 0);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  initial begin
    int streams;
    logic [3:0] bpv_pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset width of 8 is a straight copy
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h80, 1'b0);
    put(8'h7F, 1'b1);
    settle();

    // width 3: one full byte, then a padded last byte
    write_reg(REG_BITS_PER_VALUE, 4'd3);
    write_reg(REG_SIGN_MODE, 4'd0);
    put(8'hFF, 1'b0);
    put(8'h00, 1'b0);
    put(8'hAA, 1'b0);
    put(8'h55, 1'b1);
    settle();

    // width 4: last item ends on a byte boundary, no pad byte
    write_reg(REG_BITS_PER_VALUE, 4'd4);
    put(8'h5A, 1'b0);
    put(8'hC3, 1'b1);
    settle();

    // width zero behaves as one
    write_reg(REG_BITS_PER_VALUE, 4'd0);
    put(8'h01, 1'b1);
    settle();

    // widths above eight behave as eight
    write_reg(REG_BITS_PER_VALUE, 4'd15);
    put(8'hA5, 1'b1);
    settle();

    // sign mode: zero, positive and negative boundaries, eight bits make one byte
    write_reg(REG_SIGN_MODE, 4'd1);
    put(8'h00, 1'b0);
    put(8'h01, 1'b0);
    put(8'h7F, 1'b0);
    put(8'h80, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h40, 1'b0);
    put(8'h81, 1'b0);
    put(8'h02, 1'b1);
    settle();

    // width changed with bits waiting; the last item then gives two bytes
    write_reg(REG_SIGN_MODE, 4'd0);
    write_reg(REG_BITS_PER_VALUE, 4'd5);
    put(8'h1F, 1'b0);
    settle();
    write_reg(REG_BITS_PER_VALUE, 4'd7);
    put(8'h7F, 1'b1);
    settle();

    // random phases: new settings, mostly complete streams, sometimes one left open
    // so its waiting bits carry into the next setting
    while (items_total < 1800) begin
      case ($urandom_range(0, 5))
        0: bpv_pick = 4'd1;
        1: bpv_pick = 4'd8;
        default: bpv_pick = 4'($urandom_range(0, 15));
      endcase
      write_reg(REG_BITS_PER_VALUE, bpv_pick);
      // upper data bits are don't-care for the sign register
      write_reg(REG_SIGN_MODE, {3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0)});
      streams = $urandom_range(1, 4);
      for (int s = 0; s < streams; s++)
        add_items($urandom_range(1, 24), s != streams - 1 || $urandom_range(0, 3) != 0);
      if (items_total > 1530) no_idle = 1'b1;
      settle();
    end

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS bit_width_packer");
    end else begin
      $display("FAIL bit_width_packer");
    end
    $finish;
  end

endmodule

[bit_width_packer.f]
+incdir+src
src/bwp_pkg.sv
src/bwp_front.sv
src/bwp_queue.sv
src/bwp_back.sv
src/bit_width_packer.sv
tb/bit_width_packer_test.sv
